/* rtl/bkc_pkg.sv */
`default_nettype none
package bkc_pkg;

	localparam int CHUNK_BITS = 4;
	localparam int MOD_BITS   = 31;
	localparam int CNT_BITS   = $clog2(MOD_BITS);
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_SEED = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_EMIT_END   = 2'd2;

	localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(2);

	localparam logic RESULT_CHUNK = 1'b0;
	localparam logic RESULT_END   = 1'b1;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_RED     = 6'b000010,
		S_MUL     = 6'b000100,
		S_PUT     = 6'b001000,
		S_END     = 6'b010000,
		S_PUT_END = 6'b100000
	} seq_state_t;

endpackage
`default_nettype wire

/* rtl/bbs_keystream_nibble_cipher.sv */
// Sequence: an accepted request reduces the state (S_RED), squares it (S_MUL) and presents the
// chunk result from S_PUT once the output register is free; the end-state result, when enabled,
// follows via S_END and S_PUT_END. A new request is taken only in S_IDLE, after the last one is
// through. One shared modular shift-add-reduce unit takes one multiplier bit per cycle, first to
// reduce the state, then to square it, and for an end-state result to square the new state again.
// Reset: asynchronous, active low; clears the generator state and sets modulus 2, seed 0.
`default_nettype none
module bbs_keystream_nibble_cipher
	import bkc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CHUNK_BITS-1:0]   chunk_in,
	input  wire logic                    first_chunk,
	input  wire logic                    last_chunk,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [CHUNK_BITS-1:0]        chunk_out,
	output logic [MOD_BITS-1:0]          end_state,
	output logic                         result_kind,
	output logic                         last_result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [MOD_BITS-1:0]     cfg_data
);

	seq_state_t                st_q;
	logic [MOD_BITS-1:0]       mod_q;
	logic [MOD_BITS-1:0]       seed_q;
	logic                      emit_q;
	logic [MOD_BITS-1:0]       gen_q;
	logic [MOD_BITS-1:0]       x_q;
	logic [MOD_BITS-1:0]       a_q;
	logic [MOD_BITS-1:0]       r_q;
	logic [CNT_BITS-1:0]       cnt_q;
	logic [CHUNK_BITS-1:0]     chunk_q;
	logic                      extra_q;
	logic                      out_valid_q;
	logic [CHUNK_BITS-1:0]     chunk_out_q;
	logic [MOD_BITS-1:0]       end_state_q;
	logic                      kind_q;
	logic                      last_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      out_load;
	logic                      mod_small;
	logic                      step_done;
	logic [MOD_BITS-1:0]       addend;
	logic [MOD_BITS+1:0]       t_sum;
	logic [MOD_BITS+1:0]       n1;
	logic [MOD_BITS+1:0]       n2;
	logic [MOD_BITS-1:0]       r_next;
	logic [MOD_BITS-1:0]       sq_res;

	assign in_ready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = ((st_q == S_PUT) || (st_q == S_PUT_END)) && out_free;
	assign mod_small = (mod_q < MOD_BITS'(2));
	assign step_done = (cnt_q == '0);

	// One step of interleaved modular multiplication: r = (2r + bit * a) mod n, with r, a < n.
	always_comb begin
		addend = x_q[cnt_q] ? a_q : '0;
		t_sum  = {1'b0, r_q, 1'b0} + {2'b00, addend};
		n1     = {2'b00, mod_q};
		n2     = {1'b0, mod_q, 1'b0};
		if (t_sum >= n2) begin
			r_next = MOD_BITS'(t_sum - n2);
		end else if (t_sum >= n1) begin
			r_next = MOD_BITS'(t_sum - n1);
		end else begin
			r_next = t_sum[MOD_BITS-1:0];
		end
		sq_res = mod_small ? '0 : r_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= MODULUS_RESET;
			seed_q <= '0;
			emit_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODULUS:    mod_q  <= cfg_data;
				REG_START_SEED: seed_q <= cfg_data;
				REG_EMIT_END:   emit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chunk_out_q <= '0;
			end_state_q <= '0;
			kind_q      <= RESULT_CHUNK;
			last_q      <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			if (st_q == S_PUT_END) begin
				chunk_out_q <= '0;
				end_state_q <= r_q;
				kind_q      <= RESULT_END;
				last_q      <= 1'b1;
			end else begin
				chunk_out_q <= chunk_q ^ gen_q[CHUNK_BITS-1:0];
				end_state_q <= '0;
				kind_q      <= RESULT_CHUNK;
				last_q      <= !extra_q;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			gen_q   <= '0;
			cnt_q   <= '0;
			extra_q <= 1'b0;
			chunk_q <= '0;
			x_q     <= '0;
			a_q     <= '0;
			r_q     <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						chunk_q <= chunk_in;
						extra_q <= last_chunk && emit_q;
						x_q     <= first_chunk ? seed_q : gen_q;
						a_q     <= MOD_BITS'(1);
						r_q     <= '0;
						cnt_q   <= CNT_BITS'(MOD_BITS - 1);
						st_q    <= S_RED;
					end
				end
				S_RED: begin
					if (step_done) begin
						a_q   <= r_next;
						r_q   <= '0;
						cnt_q <= CNT_BITS'(MOD_BITS - 1);
						st_q  <= S_MUL;
					end else begin
						r_q   <= r_next;
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				S_MUL: begin
					r_q   <= r_next;
					cnt_q <= cnt_q - CNT_BITS'(1);
					if (step_done) begin
						gen_q <= sq_res;
						st_q  <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (extra_q) begin
							x_q   <= gen_q;
							a_q   <= gen_q;
							r_q   <= '0;
							cnt_q <= CNT_BITS'(MOD_BITS - 1);
							st_q  <= S_END;
						end else begin
							st_q <= S_IDLE;
						end
					end
				end
				S_END: begin
					if (step_done) begin
						r_q  <= sq_res;
						st_q <= S_PUT_END;
					end else begin
						r_q   <= r_next;
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				S_PUT_END: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign chunk_out   = chunk_out_q;
	assign end_state   = end_state_q;
	assign result_kind = kind_q;
	assign last_result = last_q;

	a_end_needs_extra: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_PUT_END) |-> extra_q)
		else $error("end-state result without end-state request");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == RESULT_END)) |-> last_q)
		else $error("end-state result not marked last");

	a_state_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == S_PUT) && !mod_small) |-> (gen_q < mod_q))
		else $error("generator state not reduced below modulus");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request accepted while squaring unit busy");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;
	import bkc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [MOD_BITS-1:0] MOD_MAX = {MOD_BITS{1'b1}};
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHUNK_BITS-1:0] chunk;
		logic [MOD_BITS-1:0]   end_value;
		logic                  kind;
		logic                  closing;
	} cipher_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [CHUNK_BITS-1:0]   chunk_in;
	logic                    first_chunk;
	logic                    last_chunk;
	logic                    out_valid;
	logic                    out_ready;
	logic [CHUNK_BITS-1:0]   chunk_out;
	logic [MOD_BITS-1:0]     end_state;
	logic                    result_kind;
	logic                    last_result;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [MOD_BITS-1:0]     cfg_data;

	logic [MOD_BITS-1:0] model_modulus;
	logic [MOD_BITS-1:0] model_seed;
	logic                model_emit;
	logic [MOD_BITS-1:0] model_state;

	cipher_result_t expected_results[$];
	int          error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned chunks_sent = 0;
	bit          idle_on = 1'b1;

	bbs_keystream_nibble_cipher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.chunk_in    (chunk_in),
		.first_chunk (first_chunk),
		.last_chunk  (last_chunk),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chunk_out   (chunk_out),
		.end_state   (end_state),
		.result_kind (result_kind),
		.last_result (last_result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [MOD_BITS-1:0] bbs_square(input logic [MOD_BITS-1:0] x,
			input logic [MOD_BITS-1:0] n);
		logic [63:0] product;
		if (n < 2)
			return '0;
		product = 64'(x) * 64'(x);
		return MOD_BITS'(product % 64'(n));
	endfunction

	function automatic void predict_chunk(input logic [CHUNK_BITS-1:0] chunk,
			input logic is_first, input logic is_last);
		cipher_result_t res;
		logic           extra;
		if (is_first)
			model_state = model_seed;
		model_state = bbs_square(model_state, model_modulus);
		extra = is_last && model_emit;
		res.chunk = chunk ^ model_state[CHUNK_BITS-1:0];
		res.end_value = '0;
		res.kind = RESULT_CHUNK;
		res.closing = !extra;
		expected_results.push_back(res);
		if (extra) begin
			res.chunk = '0;
			res.end_value = bbs_square(model_state, model_modulus);
			res.kind = RESULT_END;
			res.closing = 1'b1;
			expected_results.push_back(res);
		end
	endfunction

	task automatic send_chunk(input logic [CHUNK_BITS-1:0] chunk, input logic is_first,
			input logic is_last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid = 1'b1;
		chunk_in = chunk;
		first_chunk = is_first;
		last_chunk = is_last;
		do @(posedge clk); while (!in_ready);
		predict_chunk(chunk, is_first, is_last);
		chunks_sent++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] index,
			input logic [MOD_BITS-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_MODULUS:    model_modulus = data;
			REG_START_SEED: model_seed = data;
			REG_EMIT_END:   model_emit = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic [MOD_BITS-1:0] modulus,
			input logic [MOD_BITS-1:0] seed, input logic emit);
		logic [MOD_BITS-1:0] emit_word;
		hold_until_drained();
		emit_word = MOD_BITS'($urandom());
		emit_word[0] = emit;
		cfg_write(REG_MODULUS, modulus);
		cfg_write(REG_START_SEED, seed);
		cfg_write(REG_EMIT_END, emit_word);
	endtask

	// With the reset settings and no first chunk the keystream is all zeros.
	task automatic test_reset_state();
		send_chunk(4'hF, 1'b0, 1'b0);
		send_chunk(4'h0, 1'b0, 1'b0);
		send_chunk(4'hA, 1'b0, 1'b1);
	endtask

	task automatic test_end_state_mode();
		apply_settings(MOD_MAX, 31'd123456789, 1'b1);
		send_chunk(4'h0, 1'b1, 1'b0);
		send_chunk(4'hF, 1'b0, 1'b0);
		send_chunk(4'h5, 1'b0, 1'b1);
		send_chunk(4'h9, 1'b0, 1'b0);
		send_chunk(4'hC, 1'b1, 1'b1);
		send_chunk(4'h3, 1'b1, 1'b0);
	endtask

	task automatic test_seed_above_modulus();
		apply_settings(31'd209, MOD_MAX, 1'b0);
		send_chunk(4'h3, 1'b1, 1'b0);
		send_chunk(4'h6, 1'b0, 1'b1);
		apply_settings(31'd2, 31'd3, 1'b1);
		send_chunk(4'hE, 1'b1, 1'b1);
	endtask

	task automatic test_degenerate_modulus();
		apply_settings(31'd0, 31'd77, 1'b1);
		send_chunk(4'hF, 1'b1, 1'b1);
		apply_settings(31'd1, 31'd77, 1'b0);
		send_chunk(4'h7, 1'b1, 1'b0);
		send_chunk(4'h8, 1'b0, 1'b1);
	endtask

	task automatic test_unused_index();
		apply_settings(31'd3233, 31'd1000, 1'b1);
		cfg_write(REG_UNUSED, MOD_BITS'($urandom()));
		send_chunk(4'h1, 1'b1, 1'b0);
		send_chunk(4'hD, 1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(input int unsigned item_count, input bit idling);
		int unsigned done_items;
		int unsigned phase_items;
		int unsigned msg_count;
		int unsigned msg_len;
		logic [MOD_BITS-1:0] modulus;
		done_items = 0;
		msg_count = 0;
		while (done_items < item_count) begin
			case ($urandom_range(0, 9))
				0:       modulus = MOD_BITS'($urandom_range(0, 1));
				1:       modulus = 31'd2;
				2:       modulus = 31'd3;
				3:       modulus = MOD_MAX;
				default: modulus = MOD_BITS'($urandom_range(2, 32'h7FFFFFFF));
			endcase
			apply_settings(modulus, MOD_BITS'($urandom()), 1'($urandom_range(0, 1)));
			idle_on = idling && ($urandom_range(0, 3) != 0);
			phase_items = 0;
			while (phase_items < $urandom_range(60, 200) && done_items < item_count) begin
				if (msg_count == 2 || $urandom_range(0, 9) == 0)
					hold_until_drained();
				msg_count++;
				if ($urandom_range(0, 9) < 8) begin
					msg_len = $urandom_range(1, 24);
					for (int unsigned i = 0; i < msg_len; i++)
						send_chunk(CHUNK_BITS'($urandom()), i == 0, i == msg_len - 1);
					phase_items += msg_len;
					done_items += msg_len;
				end else begin
					msg_len = $urandom_range(1, 8);
					for (int unsigned i = 0; i < msg_len; i++)
						send_chunk(CHUNK_BITS'($urandom()), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
					phase_items += msg_len;
					done_items += msg_len;
				end
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		cipher_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request waiting: chunk_out %0h end_state %0h",
					chunk_out, end_state);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (chunk_out !== want.chunk) begin
					$error("chunk_out: expected %0h, actual %0h", want.chunk, chunk_out);
					error_count++;
				end
				if (end_state !== want.end_value) begin
					$error("end_state: expected %0h, actual %0h", want.end_value, end_state);
					error_count++;
				end
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0b, actual %0b", want.kind, result_kind);
					error_count++;
				end
				if (last_result !== want.closing) begin
					$error("last_result: expected %0b, actual %0b", want.closing, last_result);
					error_count++;
				end
			end
		end
	end

	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 11) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		chunk_in = '0;
		first_chunk = 1'b0;
		last_chunk = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		model_modulus = MODULUS_RESET;
		model_seed = '0;
		model_emit = 1'b0;
		model_state = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_end_state_mode();
		test_seed_above_modulus();
		test_degenerate_modulus();
		test_unused_index();
		test_random_traffic(1280, 1'b1);
		test_random_traffic(150, 1'b0);

		hold_until_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/bkc_pkg.sv
rtl/bbs_keystream_nibble_cipher.sv
tb/testbench.sv
